// ===== rtl/dmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types and constants of the direct-mapped cache tag lookup: address
// split, field widths, controller commands and the packed result beat.
// ----------------------------------------------------------------------------
package dmc_pkg;

   // geometry: 128 lines of 32 bytes
   localparam int ADDR_W      = 32;
   localparam int OFFSET_BITS = 5;
   localparam int LINES       = 128;
   localparam int INDEX_W     = $clog2(LINES);
   localparam int BLOCK_W     = ADDR_W - OFFSET_BITS;
   localparam int TAG_W       = ADDR_W - OFFSET_BITS - INDEX_W;
   localparam int CNT_W       = 32;

   // bit positions inside the address
   localparam int INDEX_LSB = OFFSET_BITS;
   localparam int TAG_LSB   = OFFSET_BITS + INDEX_W;

   // beat widths, padded to whole bytes
   localparam int REQ_W      = ADDR_W;
   localparam int RSP_FIELDS = OFFSET_BITS + BLOCK_W + INDEX_W + TAG_W + 1 + 1
                               + TAG_W + CNT_W + CNT_W;
   localparam int RSP_W      = ((RSP_FIELDS + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_W - RSP_FIELDS;

   // commands from controller to datapath
   typedef struct packed {
      logic load;    // latch address, start tag read
      logic commit;  // resolve lookup, update store, load result register
   } dmc_cmd_type;

   // result beat, last member in the lowest bits
   typedef struct packed {
      logic [RSP_PAD_W-1:0]   pad;
      logic [CNT_W-1:0]       miss_count;
      logic [CNT_W-1:0]       hit_count;
      logic [TAG_W-1:0]       evicted_tag;
      logic                   replacement;
      logic                   miss;
      logic [TAG_W-1:0]       tag_value;
      logic [INDEX_W-1:0]     line_index;
      logic [BLOCK_W-1:0]     block_number;
      logic [OFFSET_BITS-1:0] byte_offset;
   } dmc_rsp_type;

endpackage

// ===== rtl/dmc_ram.sv =====
// ----------------------------------------------------------------------------
// dmc_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds when no read is issued.
// ----------------------------------------------------------------------------
module dmc_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/dmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmc_ctrl
// Lookup sequencer: takes an address beat, waits in LOOKUP for the tag read,
// then commits once the result register is free.
// ----------------------------------------------------------------------------
module dmc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output dmc_pkg::dmc_cmd_type cmd
);

   typedef enum logic {
      IDLE,
      LOOKUP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // result register can take a new beat this cycle
   assign slot_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == IDLE);
   assign cmd.load   = req_tvalid && (state_ff == IDLE);
   assign cmd.commit = (state_ff == LOOKUP) && slot_free;
   assign rsp_tvalid = rsp_valid_ff;

   // next state and result valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               state_in = LOOKUP;
            end
         end
         LOOKUP: begin
            if (slot_free) begin
               state_in     = IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/dmc_datapath.sv =====
// ----------------------------------------------------------------------------
// dmc_datapath
// Address split, tag store (RAM plus valid flops), compare, saturating
// hit and miss counters and the result register.
// ----------------------------------------------------------------------------
module dmc_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  dmc_pkg::dmc_cmd_type        cmd,
   input  logic [dmc_pkg::ADDR_W-1:0]  req_address,
   output dmc_pkg::dmc_rsp_type        rsp
);

   logic [dmc_pkg::ADDR_W-1:0]  addr_ff;
   logic                        valid_rd_ff;
   logic [dmc_pkg::LINES-1:0]   line_valid_ff;
   logic [dmc_pkg::CNT_W-1:0]   hit_cnt_ff, hit_cnt_in;
   logic [dmc_pkg::CNT_W-1:0]   miss_cnt_ff, miss_cnt_in;
   dmc_pkg::dmc_rsp_type        rsp_ff, rsp_in;

   logic [dmc_pkg::INDEX_W-1:0] req_index;
   logic [dmc_pkg::INDEX_W-1:0] cur_index;
   logic [dmc_pkg::TAG_W-1:0]   cur_tag;
   logic [dmc_pkg::TAG_W-1:0]   stored_tag;
   logic                        hit;

   // address split
   assign req_index = req_address[dmc_pkg::INDEX_LSB +: dmc_pkg::INDEX_W];
   assign cur_index = addr_ff[dmc_pkg::INDEX_LSB +: dmc_pkg::INDEX_W];
   assign cur_tag   = addr_ff[dmc_pkg::TAG_LSB +: dmc_pkg::TAG_W];

   // tag store, installed on every miss
   dmc_ram #(
      .WIDTH (dmc_pkg::TAG_W),
      .DEPTH (dmc_pkg::LINES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && !hit),
      .wr_addr (cur_index),
      .wr_data (cur_tag),
      .rd_en   (cmd.load),
      .rd_addr (req_index),
      .rd_data (stored_tag)
   );

   // tag compare, stored tag only counts on a valid line
   assign hit = valid_rd_ff && (stored_tag == cur_tag);

   // saturating counters and next result
   always_comb begin
      hit_cnt_in  = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      if (hit) begin
         if (hit_cnt_ff != '1) begin
            hit_cnt_in = hit_cnt_ff + 1'b1;
         end
      end else begin
         if (miss_cnt_ff != '1) begin
            miss_cnt_in = miss_cnt_ff + 1'b1;
         end
      end
      rsp_in              = '0;
      rsp_in.byte_offset  = addr_ff[dmc_pkg::OFFSET_BITS-1:0];
      rsp_in.block_number = addr_ff[dmc_pkg::ADDR_W-1:dmc_pkg::OFFSET_BITS];
      rsp_in.line_index   = cur_index;
      rsp_in.tag_value    = cur_tag;
      rsp_in.miss         = !hit;
      rsp_in.replacement  = valid_rd_ff && !hit;
      rsp_in.evicted_tag  = (valid_rd_ff && !hit) ? stored_tag : '0;
      rsp_in.hit_count    = hit_cnt_in;
      rsp_in.miss_count   = miss_cnt_in;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff     <= req_address;
         valid_rd_ff <= line_valid_ff[req_index];
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   // valid bits and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         line_valid_ff <= '0;
         hit_cnt_ff    <= '0;
         miss_cnt_ff   <= '0;
      end else if (cmd.commit) begin
         line_valid_ff[cur_index] <= 1'b1;
         hit_cnt_ff               <= hit_cnt_in;
         miss_cnt_ff              <= miss_cnt_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

// ===== rtl/direct_mapped_cache_tag_lookup.sv =====
// Flow: the tag RAM is read when an address beat is taken and written when
// the lookup commits; a commit waits until the result register is free, and
// the next address beat is not taken until the current lookup has committed.
// Reset: synchronous; clears all line valid bits and both counters at once,
// so the block takes beats in the first cycle after reset.
// ----------------------------------------------------------------------------
// direct_mapped_cache_tag_lookup
// Tag store of a 4 KB direct-mapped cache (128 lines of 32 bytes): reports
// hit or miss, evictions and saturating hit and miss counts per address.
// ----------------------------------------------------------------------------
module direct_mapped_cache_tag_lookup (
   input  logic                       clock,
   input  logic                       reset,
   // address beat
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [dmc_pkg::REQ_W-1:0]  req_tdata,  // address[31:0]
   // result beat
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // byte_offset[4:0], block_number[31:5], line_index[38:32],
   // tag_value[58:39], miss[59], replacement[60], evicted_tag[80:61],
   // hit_count[112:81], miss_count[144:113], zero pad[151:145]
   output logic [dmc_pkg::RSP_W-1:0]  rsp_tdata
);

   dmc_pkg::dmc_cmd_type cmd;
   dmc_pkg::dmc_rsp_type rsp;

   // sequencer
   dmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // lookup datapath
   dmc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_address (req_tdata[dmc_pkg::ADDR_W-1:0]),
      .rsp         (rsp)
   );

   assign rsp_tdata = rsp;

   // a taken beat blocks the input for the following cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while a lookup is in flight");

   // a hit needs an earlier miss to have filled the line
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp.miss) |-> (rsp.miss_count != '0))
      else $error("hit reported with no prior miss");

   // hits never evict
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp.miss) |-> (!rsp.replacement && rsp.evicted_tag == '0))
      else $error("hit reported with an eviction");

   // nothing is offered right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat valid after reset");

endmodule
